/* rtl/sha1_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the SHA-1 stream hasher.
// No dependencies; used by every module in rtl/.
package sha1_pkg;

	localparam int WordW  = 32;
	localparam int Rounds = 80;
	localparam int BlkCntW = 55;

	localparam logic [WordW-1:0] K0 = 32'h5A827999;
	localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
	localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
	localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

	localparam logic [WordW-1:0] IV [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;

	// input word kinds
	localparam logic CMD_ABSORB = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	// round groups
	typedef enum logic [1:0] {
		PH_CH,
		PH_PAR1,
		PH_MAJ,
		PH_PAR2
	} sha1_phase_t;

	typedef struct packed {
		logic [WordW-1:0] a;
		logic [WordW-1:0] b;
		logic [WordW-1:0] c;
		logic [WordW-1:0] d;
		logic [WordW-1:0] e;
	} sha1_work_t;

	// control from the sequencer to the message schedule
	typedef struct packed {
		logic       shift;
		logic       wr_byte;
		logic       pad;
		logic       len_wr;
		logic       zero_head;
		logic [5:0] pos;
		logic [7:0] byte_val;
	} sha1_sched_ctrl_t;

	function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v, input int s);
		rotl = (v << s) | (v >> (WordW - s));
	endfunction

endpackage

/* rtl/sha1_stream_hasher.sv */
`timescale 1ns / 1ps
// Streaming SHA-1 hasher: one message byte per input word, a finish word
// emits the 160-bit digest as five 32-bit words, A first, word E flagged by m_tlast.
// The 64th byte of a block starts a compression: the round registers are loaded,
// the 80 rounds run through the single shared round unit and the result is folded
// into the chaining words, and s_tready is low throughout. A finish pads the block
// as it is accepted; with under 56 bytes pending it writes the length and runs one
// compression, with 56 or more it compresses the padded block and then a block of
// zeros and the length. It then moves the digest into the output buffer, once the
// previous digest has left. The digest leaves from its own buffer, so new message
// bytes are taken while it drains; a further finish waits for it.
// Depends on sha1_pkg, sha1_round and sha1_msg_sched.
module sha1_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic [2:0]  m_tuser,   // [2:0] word_index
	output logic        m_tlast
);
	import sha1_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LEN,
		S_INIT,
		S_ROUND,
		S_ADD,
		S_DONE
	} state_t;

	state_t               state_q;
	logic [5:0]           fill_q;
	logic [BlkCntW-1:0]   blk_q;
	logic [63:0]          len_q;
	logic                 fin_q;
	logic                 two_q;
	logic                 head_q;
	logic [6:0]           rnd_q;
	logic [WordW-1:0]     chain_q [5];
	sha1_work_t           work_q;
	sha1_work_t           work_nxt;
	logic [WordW-1:0]     dig_q [5];
	logic [2:0]           idx_q;
	logic                 ovalid_q;
	logic [31:0]          wt;
	sha1_sched_ctrl_t     sctrl;
	logic                 in_acc;
	logic                 out_acc;

	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_acc  = m_tvalid && m_tready;
	assign m_tvalid = ovalid_q;
	assign m_tdata  = dig_q[0];
	assign m_tuser  = idx_q;
	assign m_tlast  = (idx_q == 3'd4);

	always_comb begin
		sctrl           = '0;
		sctrl.pos       = fill_q;
		sctrl.byte_val  = s_tdata;
		sctrl.zero_head = head_q;
		sctrl.wr_byte   = in_acc && (s_tuser == CMD_ABSORB);
		sctrl.pad       = in_acc && (s_tuser == CMD_FINISH);
		sctrl.len_wr    = (state_q == S_LEN);
		sctrl.shift     = (state_q == S_ROUND);
	end

	sha1_msg_sched u_sched (
		.clk  (clk),
		.ctrl (sctrl),
		.len  (len_q),
		.wt   (wt)
	);

	sha1_round u_round (
		.work (work_q),
		.wt   (wt),
		.rnd  (rnd_q),
		.nxt  (work_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			blk_q    <= '0;
			fin_q    <= 1'b0;
			two_q    <= 1'b0;
			head_q   <= 1'b0;
			rnd_q    <= '0;
			chain_q  <= IV;
			idx_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			// drain the digest buffer one word per handshake
			if (out_acc) begin
				for (int i = 0; i < 4; i++) begin
					dig_q[i] <= dig_q[i+1];
				end
				idx_q <= idx_q + 3'd1;
				if (idx_q == 3'd4) begin
					ovalid_q <= 1'b0;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (s_tuser == CMD_ABSORB) begin
							fill_q <= fill_q + 6'd1;
							if (fill_q == 6'd63) begin
								state_q <= S_INIT;
							end
						end else begin
							len_q  <= {blk_q, fill_q, 3'b000};
							fin_q  <= 1'b1;
							head_q <= 1'b0;
							if (fill_q >= 6'd56) begin
								two_q   <= 1'b1;
								state_q <= S_INIT;
							end else begin
								state_q <= S_LEN;
							end
						end
					end
				end
				S_LEN: begin
					state_q <= S_INIT;
				end
				S_INIT: begin
					work_q <= '{a: chain_q[0], b: chain_q[1], c: chain_q[2],
						d: chain_q[3], e: chain_q[4]};
					rnd_q   <= '0;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					work_q <= work_nxt;
					rnd_q  <= rnd_q + 7'd1;
					if (rnd_q == 7'(Rounds - 1)) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					chain_q[0] <= chain_q[0] + work_q.a;
					chain_q[1] <= chain_q[1] + work_q.b;
					chain_q[2] <= chain_q[2] + work_q.c;
					chain_q[3] <= chain_q[3] + work_q.d;
					chain_q[4] <= chain_q[4] + work_q.e;
					blk_q      <= blk_q + BlkCntW'(1);
					if (!fin_q) begin
						fill_q  <= '0;
						state_q <= S_IDLE;
					end else if (two_q) begin
						// second block: zeros and the length
						two_q   <= 1'b0;
						head_q  <= 1'b1;
						state_q <= S_LEN;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// hold until the previous digest has left
					if (!ovalid_q) begin
						dig_q    <= chain_q;
						idx_q    <= '0;
						ovalid_q <= 1'b1;
						chain_q  <= IV;
						blk_q    <= '0;
						fill_q   <= '0;
						fin_q    <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q |-> (idx_q <= 3'd4))
		else $error("digest word index out of range");

	a_last_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && m_tlast) |=> !m_tvalid)
		else $error("digest output still valid after word E");

	a_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND) |-> (rnd_q < 7'(Rounds)))
		else $error("round counter overrun");

	a_fill_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADD && !fin_q) |=> (fill_q == 6'd0 && state_q == S_IDLE))
		else $error("byte fill not cleared after block compression");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && ovalid_q) |=> (state_q == S_DONE))
		else $error("digest buffer overwritten while draining");
`endif

endmodule

/* rtl/sha1_round.sv */
`timescale 1ns / 1ps
// One SHA-1 round: boolean function, constant select and five-term add.
// Depends on sha1_pkg.
module sha1_round (
	input  sha1_pkg::sha1_work_t work,
	input  logic [31:0]          wt,
	input  logic [6:0]           rnd,
	output sha1_pkg::sha1_work_t nxt
);
	import sha1_pkg::*;

	sha1_phase_t      phase;
	logic [WordW-1:0] f;
	logic [WordW-1:0] kc;

	always_comb begin
		if (rnd < 7'd20) begin
			phase = PH_CH;
		end else if (rnd < 7'd40) begin
			phase = PH_PAR1;
		end else if (rnd < 7'd60) begin
			phase = PH_MAJ;
		end else begin
			phase = PH_PAR2;
		end
	end

	always_comb begin
		unique case (phase)
			PH_CH: begin
				f  = (work.b & work.c) | (~work.b & work.d);
				kc = K0;
			end
			PH_PAR1: begin
				f  = work.b ^ work.c ^ work.d;
				kc = K1;
			end
			PH_MAJ: begin
				f  = (work.b & work.c) | (work.b & work.d) | (work.c & work.d);
				kc = K2;
			end
			default: begin
				f  = work.b ^ work.c ^ work.d;
				kc = K3;
			end
		endcase
	end

	always_comb begin
		nxt.a = rotl(work.a, 5) + f + work.e + kc + wt;
		nxt.b = work.a;
		nxt.c = rotl(work.b, 30);
		nxt.d = work.c;
		nxt.e = work.d;
	end

endmodule

/* rtl/sha1_msg_sched.sv */
`timescale 1ns / 1ps
// Message block buffer and 16-word schedule window for the SHA-1 rounds.
// Depends on sha1_pkg.
module sha1_msg_sched (
	input  logic                       clk,
	input  sha1_pkg::sha1_sched_ctrl_t ctrl,
	input  logic [63:0]                len,
	output logic [31:0]                wt
);
	import sha1_pkg::*;

	logic [WordW-1:0] win_q [16];
	logic [WordW-1:0] win_d [16];
	logic [4:0]       sh;

	assign sh = {~ctrl.pos[1:0], 3'b000};
	assign wt = win_q[0];

	always_comb begin
		win_d = win_q;
		if (ctrl.shift) begin
			// advance the window; the new word enters at the top
			for (int i = 0; i < 15; i++) begin
				win_d[i] = win_q[i+1];
			end
			win_d[15] = rotl(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0], 1);
		end else if (ctrl.wr_byte) begin
			win_d[ctrl.pos[5:2]][sh +: 8] = ctrl.byte_val;
		end else if (ctrl.pad) begin
			for (int i = 0; i < 16; i++) begin
				for (int j = 0; j < 4; j++) begin
					if ({i[3:0], j[1:0]} == ctrl.pos) begin
						win_d[i][(3-j)*8 +: 8] = PAD_BYTE;
					end else if ({i[3:0], j[1:0]} > ctrl.pos) begin
						win_d[i][(3-j)*8 +: 8] = 8'h00;
					end
				end
			end
		end
		if (ctrl.len_wr) begin
			if (ctrl.zero_head) begin
				for (int i = 0; i < 14; i++) begin
					win_d[i] = '0;
				end
			end
			win_d[14] = len[63:32];
			win_d[15] = len[31:0];
		end
	end

	always_ff @(posedge clk) begin
		win_q <= win_d;
	end

endmodule
